### src/vmt_pkg.sv
// Shared types and constants for the 4x4 vector matrix transform core.
package vmt_pkg;

    localparam int unsigned NUM_COMP  = 4;
    localparam int unsigned COMP_W    = 32;   // Q16.16 component
    localparam int unsigned COEF_W    = 16;   // Q4.12 coefficient
    localparam int unsigned ROW_W     = NUM_COMP * COEF_W;
    localparam int unsigned PROD_W    = COMP_W + COEF_W;
    localparam int unsigned PAIR_W    = PROD_W + 1;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned RND_W     = SUM_W + 1;
    localparam int unsigned FRAC_DROP = 12;
    localparam int unsigned Q_W       = RND_W - FRAC_DROP;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned IDX_W     = 2;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [RND_W-1:0]  rnd_t;
    typedef logic signed [Q_W-1:0]    quot_t;
    typedef logic        [ROW_W-1:0]  row_t;
    typedef logic        [OP_W-1:0]   op_t;
    typedef logic        [IDX_W-1:0]  reg_idx_t;

    // Input forms
    localparam op_t OP_XY   = 2'd0;
    localparam op_t OP_XYZ  = 2'd1;
    localparam op_t OP_XYZW = 2'd2;

    // Register indexes
    localparam reg_idx_t REG_ROW0 = 2'd0;
    localparam reg_idx_t REG_ROW1 = 2'd1;
    localparam reg_idx_t REG_ROW2 = 2'd2;
    localparam reg_idx_t REG_ROW3 = 2'd3;

    // Identity matrix after reset
    localparam row_t ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam row_t ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam row_t ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam row_t ROW3_RESET = 64'h1000_0000_0000_0000;

    localparam comp_t ONE_Q16    = 32'sh0001_0000;
    localparam rnd_t  ROUND_HALF = RND_W'(2048);

endpackage

### src/vector_matrix_transform_core.sv
// Top level: row vector times 4x4 Q4.12 matrix, rounded and saturated to Q16.16.
//
//  channel | direction | tdata / data              | tuser / index
//  --------+-----------+---------------------------+---------------
//  s_*     | in        | in_x, in_y, in_z, in_w    | operation
//  m_*     | out       | out_x, out_y, out_z, out_w| saturated
//  cfg_*   | in        | matrix row (64 bits)      | row index
//
// Five register stages: component select, 16 multipliers, pair adds,
// column sums, round and saturate into the output register.
// One request per cycle unless m_tready stalls; results leave from the output register.
// Each stage loads when it is empty or the stage after it moves, so a stall
// at m_tready backs up stage by stage without loss or repeat.
// Reset clears all valid bits and loads the identity matrix.
module vector_matrix_transform_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [127:0]               s_tdata,   // in_x, in_y, in_z, in_w
    input  vmt_pkg::op_t               s_tuser,   // operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [127:0]               m_tdata,   // out_x, out_y, out_z, out_w
    output logic                       m_tuser,   // saturated
    input  logic                       cfg_we,
    input  vmt_pkg::reg_idx_t          cfg_index,
    input  vmt_pkg::row_t              cfg_data
);

    import vmt_pkg::*;

    row_t  row_reg [NUM_COMP];

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic  rdy1, rdy2, rdy3, rdy4, rdy5;

    comp_t comp_reg [NUM_COMP];
    comp_t comp_next [NUM_COMP];
    prod_t prod_reg [NUM_COMP][NUM_COMP];   // [row][column]
    prod_t prod_next [NUM_COMP][NUM_COMP];
    pair_t pair_reg [NUM_COMP][2];
    pair_t pair_next [NUM_COMP][2];
    sum_t  sum_reg [NUM_COMP];
    sum_t  sum_next [NUM_COMP];
    comp_t out_reg [NUM_COMP];
    comp_t out_next [NUM_COMP];
    logic  sat_reg;
    logic  sat_next;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            row_reg[3] <= ROW3_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default:  row_reg[0] <= row_reg[0];
            endcase
        end
    end

    // ---------------- flow control
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: fill in missing components
    always_comb
    begin
        comp_next[0] = s_tdata[31:0];
        comp_next[1] = s_tdata[63:32];
        comp_next[2] = s_tdata[95:64];
        comp_next[3] = s_tdata[127:96];
        case (s_tuser)
            OP_XY:
            begin
                comp_next[2] = '0;
                comp_next[3] = ONE_Q16;
            end
            OP_XYZ:
            begin
                comp_next[3] = ONE_Q16;
            end
            default:
            begin
                // four components; the unused code behaves the same
                comp_next[3] = s_tdata[127:96];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
            comp_reg <= comp_next;
    end

    // ---------------- stage 2: products
    always_comb
    begin
        for (int r = 0; r < NUM_COMP; r++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                prod_next[r][c] = PROD_W'(comp_reg[r])
                                * PROD_W'(coef_t'(row_reg[r][COEF_W*c +: COEF_W]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
            prod_reg <= prod_next;
    end

    // ---------------- stage 3: pair sums
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            pair_next[c][0] = PAIR_W'(prod_reg[0][c]) + PAIR_W'(prod_reg[1][c]);
            pair_next[c][1] = PAIR_W'(prod_reg[2][c]) + PAIR_W'(prod_reg[3][c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
            pair_reg <= pair_next;
    end

    // ---------------- stage 4: column sums, exact Q.28
    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
            sum_next[c] = SUM_W'(pair_reg[c][0]) + SUM_W'(pair_reg[c][1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
            sum_reg <= sum_next;
    end

    // ---------------- stage 5: round half up, saturate
    always_comb
    begin
        rnd_t  rnd;
        quot_t q;
        sat_next = 1'b0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            rnd = RND_W'(sum_reg[c]) + ROUND_HALF;
            q   = Q_W'(rnd >>> FRAC_DROP);
            // fits when all bits above the 32-bit sign agree with it
            if ((q[Q_W-1:COMP_W-1] == '0) || (q[Q_W-1:COMP_W-1] == '1))
            begin
                out_next[c] = q[COMP_W-1:0];
            end
            else
            begin
                sat_next    = 1'b1;
                out_next[c] = q[Q_W-1] ? {1'b1, {(COMP_W-1){1'b0}}}
                                       : {1'b0, {(COMP_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser  = sat_reg;

    // ---------------- checks
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_tready))
        else $error("input blocked while pipeline has a free stage");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request missing from first stage");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && rdy5) |=> m_tvalid)
        else $error("result lost between column sums and output");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && m_tready && !v4_reg) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule

### tb/vmt_transform_checker.sv
// Checker for the vector matrix transform core: predicts each request and compares results.
module vmt_transform_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [127:0]       s_tdata,
    input  vmt_pkg::op_t       s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [127:0]       m_tdata,
    input  logic               m_tuser,
    input  logic               cfg_we,
    input  vmt_pkg::reg_idx_t  cfg_index,
    input  vmt_pkg::row_t      cfg_data,
    output int                 fail_count,
    output int                 results_pending
);

    import vmt_pkg::*;

    typedef struct packed {
        logic         sat;
        logic [127:0] vec;   // out_x, out_y, out_z, out_w from bit 0 up
    } xform_result_t;

    localparam longint Q16_MAX  = 64'sd2147483647;
    localparam longint Q16_MIN  = -64'sd2147483648;
    localparam longint HALF_LSB = 64'sd2048;

    row_t          matrix [NUM_COMP];
    xform_result_t awaited_results [$];
    string         out_names [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

    function automatic xform_result_t transform_vector(op_t op, logic [127:0] vin);
        longint        v [NUM_COMP];
        longint        acc;
        longint        q;
        xform_result_t res;
        v[0] = longint'($signed(vin[31:0]));
        v[1] = longint'($signed(vin[63:32]));
        if (op == OP_XY)
            v[2] = 0;
        else
            v[2] = longint'($signed(vin[95:64]));
        // w defaults to 1.0 for the short forms; the spare code takes all four
        if (op == OP_XY || op == OP_XYZ)
            v[3] = longint'(ONE_Q16);
        else
            v[3] = longint'($signed(vin[127:96]));
        res.sat = 1'b0;
        res.vec = '0;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            acc = 0;
            for (int r = 0; r < NUM_COMP; r++)
                acc += v[r] * longint'($signed(matrix[r][COEF_W*c +: COEF_W]));
            // floor after adding half: ties go towards plus infinity
            q = (acc + HALF_LSB) >>> FRAC_DROP;
            if (q > Q16_MAX)
            begin
                q = Q16_MAX;
                res.sat = 1'b1;
            end
            else if (q < Q16_MIN)
            begin
                q = Q16_MIN;
                res.sat = 1'b1;
            end
            res.vec[COMP_W*c +: COMP_W] = q[COMP_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        xform_result_t want;
        int            errs;
        if (!rst_n)
        begin
            matrix[0] <= ROW0_RESET;
            matrix[1] <= ROW1_RESET;
            matrix[2] <= ROW2_RESET;
            matrix[3] <= ROW3_RESET;
            awaited_results.delete();
            results_pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                matrix[cfg_index] <= cfg_data;
            if (s_tvalid && s_tready)
                awaited_results.push_back(transform_vector(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result %h/%b with no request outstanding", m_tdata, m_tuser);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    for (int i = 0; i < NUM_COMP; i++)
                        if (m_tdata[COMP_W*i +: COMP_W] !== want.vec[COMP_W*i +: COMP_W])
                        begin
                            $error("%s: expected %0d, got %0d", out_names[i],
                                   $signed(want.vec[COMP_W*i +: COMP_W]),
                                   $signed(m_tdata[COMP_W*i +: COMP_W]));
                            errs++;
                        end
                    if (m_tuser !== want.sat)
                    begin
                        $error("saturated: expected %b, got %b", want.sat, m_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            results_pending <= awaited_results.size();
        end
    end

endmodule

### tb/tb_vector_matrix_transform_core.sv
// Testbench top: stimulus, pacing and verdict for the vector matrix transform core.
module tb_vector_matrix_transform_core;
    import vmt_pkg::*;

    localparam op_t   OP_SPARE      = 2'd3;      // unused code, behaves as four components
    localparam comp_t COMP_MAX      = 32'sh7FFF_FFFF;
    localparam comp_t COMP_MIN      = 32'sh8000_0000;
    localparam comp_t COMP_LSB      = 32'sh0000_0001;
    localparam coef_t COEF_POS_MAX  = 16'sh7FFF;
    localparam coef_t COEF_NEG_MAX  = 16'sh8000;
    localparam coef_t COEF_HALF     = 16'sh0800;
    localparam coef_t COEF_NEG_HALF = 16'shF800;
    localparam coef_t COEF_NEG_LSB  = 16'shFFFF;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    PHASES        = 8;
    localparam int    PHASE_ITEMS   = 180;
    localparam int    CALM_ITEMS    = 40;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    op_t           s_tuser = OP_XY;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;
    logic          m_tuser;
    logic          cfg_we = 1'b0;
    reg_idx_t      cfg_index = REG_ROW0;
    row_t          cfg_data = '0;

    int            fail_count;
    int            results_pending;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            hold_requests = 0;

    always #2 clk = ~clk;

    vector_matrix_transform_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vmt_transform_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Result side: random back-pressure, plus a long hold-off on demand
    initial
    begin : ready_gen
        int held;
        int seen;
        held = 0;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != seen)
            begin
                seen = hold_requests;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_pace(input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
    endtask

    // Called at a rising edge; returns at the edge where the request is taken
    task automatic send_vector(input op_t op, input comp_t x, input comp_t y,
                               input comp_t z, input comp_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {w, z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_until_empty();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_matrix(input row_t r0, input row_t r1, input row_t r2, input row_t r3);
        row_t     rows [NUM_COMP];
        reg_idx_t idx [NUM_COMP];
        rows = '{r0, r1, r2, r3};
        idx  = '{REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3};
        for (int i = 0; i < NUM_COMP; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= rows[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic comp_t pick_component();
        case ($urandom_range(11))
            0: return COMP_MAX;
            1: return COMP_MIN;
            2: return '0;
            3: return ONE_Q16;
            4: return -ONE_Q16;
            5, 6, 7: return comp_t'(int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic row_t make_row(input int flavour);
        row_t row;
        case (flavour)
            1: row = {NUM_COMP{COEF_NEG_LSB}};
            2: row = {NUM_COMP{COEF_POS_MAX}};
            3: row = {NUM_COMP{COEF_NEG_MAX}};
            4, 7: row = {$urandom, $urandom};
            default:
                // modest coefficients, within about two either side of zero
                for (int c = 0; c < NUM_COMP; c++)
                    row[COEF_W*c +: COEF_W] = coef_t'(int'($urandom_range(16'h4000)) - 16'sh2000);
        endcase
        return row;
    endfunction

    initial
    begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        row_t mixed;
        mixed = {COEF_HALF, COEF_NEG_HALF, COEF_POS_MAX, COEF_NEG_MAX};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset; ignored components carry junk
        set_pace(23, 23);
        send_vector(OP_XY, ONE_Q16, -ONE_Q16, COMP_MAX, COMP_MIN);
        send_vector(OP_XYZ, COMP_MAX, COMP_MIN, ONE_Q16, comp_t'(32'sh1234_5678));
        send_vector(OP_XYZW, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX);
        send_vector(OP_SPARE, comp_t'(32'sh0003_8000), -COMP_LSB, COMP_MAX, COMP_MIN);
        send_vector(OP_XYZW, '0, '0, '0, '0);
        send_vector(OP_XY, COMP_LSB, -COMP_LSB, '0, '0);
        pause_until_empty();

        // halves give exact ties in the rounding, the big coefficients saturate
        load_matrix(mixed, mixed, mixed, mixed);
        send_vector(OP_XYZW, COMP_LSB, '0, '0, '0);
        send_vector(OP_XYZW, -COMP_LSB, '0, '0, '0);
        send_vector(OP_XYZW, '0, COMP_LSB, '0, '0);
        send_vector(OP_XYZW, '0, '0, '0, -COMP_LSB);
        send_vector(OP_XYZW, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        send_vector(OP_XYZW, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_vector(OP_XY, COMP_MAX, COMP_MAX, COMP_MIN, COMP_MIN);
        send_vector(OP_XYZ, comp_t'(3), comp_t'(-3), comp_t'(5), COMP_MAX);
        send_vector(OP_SPARE, comp_t'($urandom), comp_t'($urandom),
                    comp_t'($urandom), comp_t'($urandom));
        pause_until_empty();

        load_matrix('0, '0, '0, '0);
        send_vector(OP_XYZW, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);
        send_vector(OP_XY, COMP_MIN, COMP_MAX, '0, '0);
        pause_until_empty();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET);
            else
                load_matrix(make_row(phase), make_row(phase), make_row(phase), make_row(phase));
            set_pace(0, 0);
            // starve the output so the pipe fills and the input stalls
            if (phase % 4 == 0)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == CALM_ITEMS)
                    case (phase % 4)
                        0: set_pace(0, 0);
                        1: set_pace(88, 0);
                        2: set_pace(0, 88);
                        default: set_pace(23, 23);
                    endcase
                send_vector(op_t'($urandom_range(3)), pick_component(), pick_component(),
                            pick_component(), pick_component());
            end
            pause_until_empty();
        end

        if (fail_count == 0 && results_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
